[src/mcw_pkg.sv]
// ----------------------------------------------------------------------------
// Minimum covering window package
// Shared sizes, codes, memory request structures and sequencer states.
// ----------------------------------------------------------------------------
package mcw_pkg;

  localparam int MAX_TEXT  = 4096;
  localparam int TEXT_AW   = $clog2(MAX_TEXT);
  localparam int POS_W     = $clog2(MAX_TEXT + 1);
  localparam int NEED_W    = $clog2(MAX_TEXT + 2) + 1;
  localparam int BYTE_W    = 8;
  localparam int NUM_KINDS = 1 << BYTE_W;
  localparam int KIND_W    = BYTE_W + 1;
  localparam int START_W   = 12;
  localparam int LEN_W     = 13;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } opcode_t;

  typedef struct packed {
    logic              in_pat;
    logic [NEED_W-1:0] need;
  } cnt_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [BYTE_W-1:0] rd_addr;
    logic              wr_en;
    logic [BYTE_W-1:0] wr_addr;
    cnt_entry_t        wr_data;
    logic              clear;
  } cnt_req_t;

  typedef struct packed {
    logic               rd_en;
    logic [TEXT_AW-1:0] rd_addr;
    logic               wr_en;
    logic [TEXT_AW-1:0] wr_addr;
    logic [BYTE_W-1:0]  wr_data;
  } text_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SH_TEXT,
    ST_SH_COUNT,
    ST_SH_EVAL,
    ST_BEST,
    ST_FINISH
  } state_t;

endpackage

[src/mcw_item_if.sv]
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one pattern or text byte per transaction.
// ----------------------------------------------------------------------------
interface mcw_item_if;
  import mcw_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [BYTE_W-1:0] ch;
  logic              last;

  modport source (output valid, opcode, ch, last, input ready);
  modport sink (input valid, opcode, ch, last, output ready);
endinterface

[src/mcw_result_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one search result per transaction.
// ----------------------------------------------------------------------------
interface mcw_result_if;
  import mcw_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [START_W-1:0] start_res;
  logic [LEN_W-1:0]   length;
  logic               overflow;

  modport source (output valid, found, start_res, length, overflow, input ready);
  modport sink (input valid, found, start_res, length, overflow, output ready);
endinterface

[src/mcw_text_mem.sv]
// ----------------------------------------------------------------------------
// Text window buffer
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mcw_text_mem (
  input  logic                      clk,
  input  mcw_pkg::text_req_t        req,
  output logic [mcw_pkg::BYTE_W-1:0] rd_data
);
  import mcw_pkg::*;

  logic [BYTE_W-1:0] mem [MAX_TEXT];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end
endmodule

[src/mcw_count_mem.sv]
// ----------------------------------------------------------------------------
// Per-byte count table
// Holds the pattern flag and outstanding need of every byte value. A row of
// valid bits lets one clear request make the whole table read as zero again.
// ----------------------------------------------------------------------------
module mcw_count_mem (
  input  logic                clk,
  input  logic                rst,
  input  mcw_pkg::cnt_req_t   req,
  output mcw_pkg::cnt_entry_t rd_entry
);
  import mcw_pkg::*;

  cnt_entry_t           mem [NUM_KINDS];
  logic [NUM_KINDS-1:0] entry_valid;
  cnt_entry_t           rd_data;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data  <= mem[req.rd_addr];
      rd_valid <= entry_valid[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      entry_valid <= '0;
    end else if (req.wr_en) begin
      entry_valid[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_entry = rd_valid ? rd_data : '0;
endmodule

[src/minimum_covering_window_core.sv]
// ----------------------------------------------------------------------------
// Minimum covering window core
// Finds the shortest stretch of a text stream that holds every pattern byte.
//
// Items arrive on the item channel: opcode 0 loads a pattern byte, opcode 1
// scans a text byte, and last on a text byte closes the run. That byte makes
// one transaction on the result channel with found, start_res, length and
// overflow, after which all tables and counters return to their reset state.
// A pattern byte passes the idle and update states, and a text byte the idle,
// update and finish states; when the window is covered after a text byte, the
// shrink loop of text read, count read and evaluate steps over the left end of
// the window until a byte may not be dropped, and the best state then checks
// the cover. Each text byte is dropped at most once, and no new item is taken
// until the block is idle again. The result transaction is offered from the
// cycle after the closing byte's last cycle. The result is held until taken;
// the next item is accepted while it waits, and only another closing byte
// stalls until the register is free. Reset is synchronous and leaves the
// block ready at once: the count table is cleared by its valid bits, and the
// text buffer needs no clearing.
// ----------------------------------------------------------------------------
module minimum_covering_window_core (
  input logic          clk,
  input logic          rst,
  mcw_item_if.sink     item,
  mcw_result_if.source result
);
  import mcw_pkg::*;

  state_t              state;
  state_t              state_next;
  logic                op_q;
  logic [BYTE_W-1:0]   ch_q;
  logic                last_q;
  logic [BYTE_W-1:0]   drop_byte;
  logic [BYTE_W-1:0]   drop_byte_next;
  logic [KIND_W-1:0]   missing;
  logic [KIND_W-1:0]   missing_next;
  logic [POS_W-1:0]    left_pos;
  logic [POS_W-1:0]    left_pos_next;
  logic [POS_W-1:0]    right_pos;
  logic [POS_W-1:0]    right_pos_next;
  logic [POS_W-1:0]    best_len;
  logic [POS_W-1:0]    best_len_next;
  logic [POS_W-1:0]    best_start;
  logic [POS_W-1:0]    best_start_next;
  logic                overflowed;
  logic                overflowed_next;
  logic                pattern_seen;
  logic                pattern_seen_next;
  logic                out_valid;
  logic                out_load;
  logic                out_found;
  logic [START_W-1:0]  out_start;
  logic [LEN_W-1:0]    out_length;
  logic                out_overflow;

  cnt_req_t            cnt_req;
  cnt_entry_t          cnt_rd;
  text_req_t           text_req;
  logic [BYTE_W-1:0]   text_rd;

  logic [NEED_W-1:0]   need_inc;
  logic [NEED_W-1:0]   need_dec;
  logic [POS_W-1:0]    win_len;
  logic                accept;

  mcw_count_mem u_count (
    .clk      (clk),
    .rst      (rst),
    .req      (cnt_req),
    .rd_entry (cnt_rd)
  );

  mcw_text_mem u_text (
    .clk     (clk),
    .req     (text_req),
    .rd_data (text_rd)
  );

  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign need_inc   = cnt_rd.need + NEED_W'(1);
  assign need_dec   = cnt_rd.need - NEED_W'(1);
  assign win_len    = right_pos - left_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      missing      <= '0;
      left_pos     <= '0;
      right_pos    <= '0;
      best_len     <= '0;
      best_start   <= '0;
      overflowed   <= 1'b0;
      pattern_seen <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      missing      <= missing_next;
      left_pos     <= left_pos_next;
      right_pos    <= right_pos_next;
      best_len     <= best_len_next;
      best_start   <= best_start_next;
      overflowed   <= overflowed_next;
      pattern_seen <= pattern_seen_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= item.opcode;
      ch_q   <= item.ch;
      last_q <= item.last;
    end
    drop_byte <= drop_byte_next;
    if (out_load) begin
      out_found    <= (best_len != '0);
      out_start    <= (best_len != '0) ? START_W'(best_start) : '0;
      out_length   <= LEN_W'(best_len);
      out_overflow <= overflowed;
    end
  end

  always_comb begin
    state_next        = state;
    missing_next      = missing;
    left_pos_next     = left_pos;
    right_pos_next    = right_pos;
    best_len_next     = best_len;
    best_start_next   = best_start;
    overflowed_next   = overflowed;
    pattern_seen_next = pattern_seen;
    drop_byte_next    = drop_byte;
    out_load          = 1'b0;
    cnt_req           = '0;
    text_req          = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          cnt_req.rd_en   = 1'b1;
          cnt_req.rd_addr = item.ch;
          state_next      = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        if (op_q == OP_PATTERN) begin
          pattern_seen_next = 1'b1;
          cnt_req.wr_en          = 1'b1;
          cnt_req.wr_addr        = ch_q;
          cnt_req.wr_data.in_pat = 1'b1;
          cnt_req.wr_data.need   = cnt_rd.need;
          if ($signed(cnt_rd.need) < $signed(NEED_W'(MAX_TEXT + 1))) begin
            cnt_req.wr_data.need = need_inc;
            if (need_inc == NEED_W'(1)) begin
              missing_next = missing + KIND_W'(1);
            end
          end
          state_next = ST_IDLE;
        end else if (right_pos >= POS_W'(MAX_TEXT)) begin
          overflowed_next = 1'b1;
          state_next      = ST_FINISH;
        end else begin
          text_req.wr_en   = 1'b1;
          text_req.wr_addr = right_pos[TEXT_AW-1:0];
          text_req.wr_data = ch_q;
          right_pos_next   = right_pos + POS_W'(1);
          if (cnt_rd.in_pat) begin
            cnt_req.wr_en          = 1'b1;
            cnt_req.wr_addr        = ch_q;
            cnt_req.wr_data.in_pat = 1'b1;
            cnt_req.wr_data.need   = need_dec;
            if (need_dec == '0) begin
              missing_next = missing - KIND_W'(1);
            end
          end
          if (pattern_seen && missing_next == '0) begin
            state_next = ST_SH_TEXT;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end

      ST_SH_TEXT: begin
        if (left_pos < right_pos) begin
          text_req.rd_en   = 1'b1;
          text_req.rd_addr = left_pos[TEXT_AW-1:0];
          state_next       = ST_SH_COUNT;
        end else begin
          state_next = ST_BEST;
        end
      end

      ST_SH_COUNT: begin
        drop_byte_next  = text_rd;
        cnt_req.rd_en   = 1'b1;
        cnt_req.rd_addr = text_rd;
        state_next      = ST_SH_EVAL;
      end

      ST_SH_EVAL: begin
        if (!cnt_rd.in_pat) begin
          left_pos_next = left_pos + POS_W'(1);
          state_next    = ST_SH_TEXT;
        end else if (cnt_rd.need[NEED_W-1]) begin
          cnt_req.wr_en          = 1'b1;
          cnt_req.wr_addr        = drop_byte;
          cnt_req.wr_data.in_pat = 1'b1;
          cnt_req.wr_data.need   = need_inc;
          left_pos_next          = left_pos + POS_W'(1);
          state_next             = ST_SH_TEXT;
        end else begin
          state_next = ST_BEST;
        end
      end

      ST_BEST: begin
        if (best_len == '0 || win_len < best_len) begin
          best_len_next   = win_len;
          best_start_next = left_pos;
        end
        state_next = ST_FINISH;
      end

      ST_FINISH: begin
        if (op_q == OP_TEXT && last_q) begin
          if (!out_valid || result.ready) begin
            out_load          = 1'b1;
            cnt_req.clear     = 1'b1;
            missing_next      = '0;
            left_pos_next     = '0;
            right_pos_next    = '0;
            best_len_next     = '0;
            best_start_next   = '0;
            overflowed_next   = 1'b0;
            pattern_seen_next = 1'b0;
            state_next        = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign result.valid     = out_valid;
  assign result.found     = out_found;
  assign result.start_res = out_start;
  assign result.length    = out_length;
  assign result.overflow  = out_overflow;
endmodule

[dv/mcw_window_checker.sv]
// ----------------------------------------------------------------------------
// Minimum covering window checker
// Watches the item and result channels of the core and keeps its own model
// of the count table, the window buffer and the best cover. Every closing
// text byte queues the report the core should send, and each result
// transaction is compared against the oldest queued report.
// ----------------------------------------------------------------------------
module mcw_window_checker (
  input logic   clk,
  input logic   rst,
  mcw_item_if   item,
  mcw_result_if result,
  output int    failures,
  output int    outstanding
);
  import mcw_pkg::*;

  localparam int NEED_CAP = MAX_TEXT + 1;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start_res;
    logic [LEN_W-1:0]   length;
    logic               overflow;
  } window_report_t;

  logic                     in_pat [NUM_KINDS];
  logic signed [NEED_W-1:0] need [NUM_KINDS];
  logic [BYTE_W-1:0]        text_buf [MAX_TEXT];
  logic [KIND_W-1:0]        missing;
  logic [POS_W-1:0]         left_pos;
  logic [POS_W-1:0]         right_pos;
  logic [LEN_W-1:0]         best_len;
  logic [START_W-1:0]       best_start;
  logic                     overflowed;
  logic                     pattern_loaded;
  window_report_t           window_reports [$];
  int                       mismatches = 0;
  int                       waiting = 0;

  assign failures    = mismatches;
  assign outstanding = waiting;

  function automatic void clear_search();
    for (int k = 0; k < NUM_KINDS; k++) begin
      in_pat[k] = 1'b0;
      need[k]   = '0;
    end
    missing        = '0;
    left_pos       = '0;
    right_pos      = '0;
    best_len       = '0;
    best_start     = '0;
    overflowed     = 1'b0;
    pattern_loaded = 1'b0;
  endfunction

  function automatic void tally_pattern(logic [BYTE_W-1:0] c);
    in_pat[c]      = 1'b1;
    pattern_loaded = 1'b1;
    if (need[c] < NEED_CAP) begin
      need[c] = need[c] + 1;
      if (need[c] == 1) missing = missing + 1;
    end
  endfunction

  function automatic void scan_text(logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] b;
    logic [POS_W-1:0]  span;
    logic              settled;
    if (right_pos >= MAX_TEXT) begin
      overflowed = 1'b1;
      return;
    end
    text_buf[right_pos[TEXT_AW-1:0]] = c;
    right_pos = right_pos + 1;
    if (in_pat[c]) begin
      need[c] = need[c] - 1;
      if (need[c] == 0) missing = missing - 1;
    end
    if (!pattern_loaded || missing != 0) return;
    // The window is covered, so drop surplus bytes from its left end.
    settled = 1'b0;
    while (left_pos < right_pos && !settled) begin
      b = text_buf[left_pos[TEXT_AW-1:0]];
      if (!in_pat[b]) begin
        left_pos = left_pos + 1;
      end else if (need[b] < 0) begin
        need[b]  = need[b] + 1;
        left_pos = left_pos + 1;
      end else begin
        settled = 1'b1;
      end
    end
    span = right_pos - left_pos;
    if (best_len == 0 || span < best_len) begin
      best_len   = span;
      best_start = left_pos[START_W-1:0];
    end
  endfunction

  always @(posedge clk) begin
    window_report_t want;
    window_report_t got;
    if (rst) begin
      clear_search();
      window_reports.delete();
    end else begin
      if (result.valid && result.ready) begin
        got = '{result.found, result.start_res, result.length, result.overflow};
        if (window_reports.size() == 0) begin
          $display("%0t: unexpected result found=%0b start=%0d length=%0d overflow=%0b",
                   $time, got.found, got.start_res, got.length, got.overflow);
          mismatches++;
        end else begin
          want = window_reports.pop_front();
          if (got.found !== want.found || got.start_res !== want.start_res ||
              got.length !== want.length || got.overflow !== want.overflow) begin
            $display("%0t: expected found=%0b start=%0d length=%0d overflow=%0b",
                     $time, want.found, want.start_res, want.length, want.overflow);
            $display("%0t: actual   found=%0b start=%0d length=%0d overflow=%0b",
                     $time, got.found, got.start_res, got.length, got.overflow);
            mismatches++;
          end
        end
      end
      if (item.valid && item.ready) begin
        if (opcode_t'(item.opcode) == OP_PATTERN) begin
          tally_pattern(item.ch);
        end else begin
          scan_text(item.ch);
          if (item.last) begin
            want.found     = (best_len != 0);
            want.start_res = (best_len != 0) ? best_start : '0;
            want.length    = best_len;
            want.overflow  = overflowed;
            window_reports.push_back(want);
            clear_search();
          end
        end
      end
    end
    waiting = window_reports.size();
  end

endmodule

[dv/minimum_covering_window_core_test.sv]
// ----------------------------------------------------------------------------
// Minimum covering window core testbench
// Drives directed runs (empty pattern, ignored closing flag on a pattern
// byte, late pattern bytes, ties and an uncoverable repeated byte), then
// random runs of pattern and text bytes over small alphabets. Both channels
// idle at random until the final stretch. The checker reports mismatches.
// ----------------------------------------------------------------------------
module minimum_covering_window_core_test;
  import mcw_pkg::*;

  localparam int RANDOM_ITEMS = 1030;
  localparam int QUIET_AFTER  = 880;

  logic clk;
  logic rst;
  bit   quiet;
  int   sent;
  int   failures;
  int   outstanding;

  mcw_item_if   item_ch ();
  mcw_result_if result_ch ();

  minimum_covering_window_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  mcw_window_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #12000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_item(input opcode_t op, input logic [BYTE_W-1:0] c, input logic lst);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    item_ch.valid  <= 1'b1;
    item_ch.opcode <= op;
    item_ch.ch     <= c;
    item_ch.last   <= lst;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  initial begin
    result_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  initial begin
    logic [BYTE_W-1:0] alpha [4];
    logic [BYTE_W-1:0] c;
    int                pick;
    int                plen;
    int                tlen;
    int                base;
    rst            = 1'b1;
    quiet          = 1'b0;
    sent           = 0;
    item_ch.valid  = 1'b0;
    item_ch.opcode = OP_PATTERN;
    item_ch.ch     = '0;
    item_ch.last   = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty pattern never covers.
    send_item(OP_TEXT, 8'h00, 1'b0);
    send_item(OP_TEXT, 8'hFF, 1'b1);
    // The closing flag on a pattern byte is ignored; equal covers keep the first.
    send_item(OP_PATTERN, 8'h61, 1'b1);
    send_item(OP_PATTERN, 8'h62, 1'b0);
    send_item(OP_TEXT, 8'h61, 1'b0);
    send_item(OP_TEXT, 8'h62, 1'b0);
    send_item(OP_TEXT, 8'h61, 1'b1);
    // A repeated pattern byte that the text cannot cover.
    send_item(OP_PATTERN, 8'hFF, 1'b0);
    send_item(OP_PATTERN, 8'hFF, 1'b0);
    send_item(OP_TEXT, 8'hFF, 1'b1);
    // A pattern byte after text raises the need but keeps the recorded cover.
    send_item(OP_PATTERN, 8'h10, 1'b0);
    send_item(OP_TEXT, 8'h10, 1'b0);
    send_item(OP_PATTERN, 8'h20, 1'b0);
    send_item(OP_TEXT, 8'h20, 1'b1);
    send_item(OP_PATTERN, 8'h00, 1'b0);
    send_item(OP_TEXT, 8'h00, 1'b1);

    base = sent;
    while (sent - base < RANDOM_ITEMS) begin
      for (int k = 0; k < 4; k++) alpha[k] = BYTE_W'($urandom_range(0, 255));
      pick = $urandom_range(1, 4);
      plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      tlen = $urandom_range(1, 40);
      for (int i = 0; i < plen; i++)
        send_item(OP_PATTERN, alpha[$urandom_range(0, pick - 1)], $urandom_range(0, 7) == 0);
      for (int i = 0; i < tlen; i++) begin
        if ($urandom_range(0, 24) == 0)
          send_item(OP_PATTERN, alpha[$urandom_range(0, pick - 1)],
                    $urandom_range(0, 1) == 1);
        c = ($urandom_range(0, 9) == 0) ? BYTE_W'($urandom_range(0, 255))
                                        : alpha[$urandom_range(0, pick - 1)];
        send_item(OP_TEXT, c, i == tlen - 1);
      end
      if (sent - base > QUIET_AFTER) quiet = 1'b1;
    end

    item_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
